FILE: sv/safety_mode_supervisor_macros.svh
// Assertion macros shared by the safety mode supervisor RTL.
// Each macro expands to one labelled concurrent assertion on clk and arst_n.
`ifndef SAFETY_MODE_SUPERVISOR_MACROS_SVH
`define SAFETY_MODE_SUPERVISOR_MACROS_SVH

// same-cycle implication
`define SMS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SMS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/smsup_pkg.sv
// Types, codes, reset values and helper functions of the safety mode supervisor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package smsup_pkg;

	localparam int unsigned MISMATCH_LIMIT_DEF = 5;
	localparam int unsigned GRACE_MS_DEF       = 3000;

	typedef enum logic [1:0] {
		MODE_MON = 2'd0,
		MODE_CMP = 2'd1,
		MODE_TRQ = 2'd2,
		MODE_STP = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		KIND_SAMPLE = 3'd0,
		KIND_TICK   = 3'd1,
		KIND_STOP   = 3'd2,
		KIND_CMP    = 3'd3,
		KIND_TRQ    = 3'd4,
		KIND_RESET  = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		CAUSE_NONE     = 3'd0,
		CAUSE_REQUEST  = 3'd1,
		CAUSE_MISMATCH = 3'd2,
		CAUSE_UNSEEN   = 3'd3,
		CAUSE_TIMEOUT  = 3'd4
	} cause_t;

	typedef enum logic [2:0] {
		REG_AUTO_DG   = 3'd0,
		REG_TAU_CMP   = 3'd1,
		REG_TAU_TRQ   = 3'd2,
		REG_VEL_CMP   = 3'd3,
		REG_VEL_TRQ   = 3'd4,
		REG_DG_TARGET = 3'd5,
		REG_PENALTY   = 3'd6,
		REG_TIMEOUT   = 3'd7
	} reg_idx_t;

	localparam logic [14:0] TAU_CMP_RST   = 15'd384;
	localparam logic [14:0] TAU_TRQ_RST   = 15'd640;
	localparam logic [14:0] VEL_CMP_RST   = 15'd205;
	localparam logic [14:0] VEL_TRQ_RST   = 15'd384;
	localparam logic [15:0] DG_TARGET_RST = 16'd2000;
	localparam logic [7:0]  PENALTY_RST   = 8'd5;
	localparam logic [15:0] TIMEOUT_RST   = 16'd500;

	typedef struct packed {
		logic        auto_downgrade_enable;
		logic [14:0] tau_cmp_exit;
		logic [14:0] tau_torque_exit;
		logic [14:0] vel_cmp_exit;
		logic [14:0] vel_torque_exit;
		logic [15:0] downgrade_target;
		logic [7:0]  penalty_weight;
		logic [15:0] liveness_timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic               set_flag;
		logic [7:0]         mode_id;
		logic signed [15:0] velocity;
		logic signed [15:0] torque;
		logic [31:0]        now_ms;
	} item_t;

	typedef struct packed {
		logic [1:0]  mode_code;
		logic        accepted;
		logic        stop_latched;
		logic        fault_flag;
		logic [2:0]  fault_cause;
		logic        drive_alive;
		logic        drive_coherent;
		logic [15:0] compliant_progress;
		logic [15:0] torque_progress;
	} result_t;

	function automatic logic [1:0] drive_mode_id(mode_t m);
		case (m)
			MODE_CMP: return 2'd2;
			MODE_TRQ: return 2'd1;
			default:  return m;
		endcase
	endfunction

	function automatic logic [16:0] mag16(logic [15:0] v);
		return v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
	endfunction

	function automatic logic [15:0] leak(logic [15:0] c, logic pos, logic [15:0] tgt,
			logic [7:0] pw);
		logic [16:0] inc;
		inc = {1'b0, c} + 17'd1;
		if (pos)
			return (inc < {1'b0, tgt}) ? inc[15:0] : tgt;
		return (c > {8'b0, pw}) ? (c - {8'b0, pw}) : 16'd0;
	endfunction

	function automatic logic allowed(mode_t tgt, mode_t cur, logic latched);
		if (latched && tgt != MODE_STP)
			return 1'b0;
		if (tgt == cur)
			return 1'b1;
		if (cur == MODE_STP)
			return tgt == MODE_MON;
		return 1'b1;
	endfunction

endpackage

FILE: sv/smsup_cfg.sv
// APB-style configuration register file of the safety mode supervisor.
// Depends on smsup_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module smsup_cfg import smsup_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_downgrade_enable <= 1'b0;
			cfg_q.tau_cmp_exit          <= TAU_CMP_RST;
			cfg_q.tau_torque_exit       <= TAU_TRQ_RST;
			cfg_q.vel_cmp_exit          <= VEL_CMP_RST;
			cfg_q.vel_torque_exit       <= VEL_TRQ_RST;
			cfg_q.downgrade_target      <= DG_TARGET_RST;
			cfg_q.penalty_weight        <= PENALTY_RST;
			cfg_q.liveness_timeout_ms   <= TIMEOUT_RST;
		end else if (wr_en) begin
			case (idx)
				REG_AUTO_DG:   cfg_q.auto_downgrade_enable <= pwdata[0];
				REG_TAU_CMP:   cfg_q.tau_cmp_exit          <= pwdata[14:0];
				REG_TAU_TRQ:   cfg_q.tau_torque_exit       <= pwdata[14:0];
				REG_VEL_CMP:   cfg_q.vel_cmp_exit          <= pwdata[14:0];
				REG_VEL_TRQ:   cfg_q.vel_torque_exit       <= pwdata[14:0];
				REG_DG_TARGET: cfg_q.downgrade_target      <= pwdata[15:0];
				REG_PENALTY:   cfg_q.penalty_weight        <= pwdata[7:0];
				REG_TIMEOUT:   cfg_q.liveness_timeout_ms   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_AUTO_DG:   prdata = {31'b0, cfg_q.auto_downgrade_enable};
			REG_TAU_CMP:   prdata = {17'b0, cfg_q.tau_cmp_exit};
			REG_TAU_TRQ:   prdata = {17'b0, cfg_q.tau_torque_exit};
			REG_VEL_CMP:   prdata = {17'b0, cfg_q.vel_cmp_exit};
			REG_VEL_TRQ:   prdata = {17'b0, cfg_q.vel_torque_exit};
			REG_DG_TARGET: prdata = {16'b0, cfg_q.downgrade_target};
			REG_PENALTY:   prdata = {24'b0, cfg_q.penalty_weight};
			REG_TIMEOUT:   prdata = {16'b0, cfg_q.liveness_timeout_ms};
			default:       prdata = 32'b0;
		endcase
	end

endmodule

FILE: sv/smsup_core.sv
// Supervisor state and single-pass next-state logic for one event word.
// Depends on smsup_pkg and safety_mode_supervisor_macros.svh.
`timescale 1ns / 1ps
`include "safety_mode_supervisor_macros.svh"

module smsup_core import smsup_pkg::*; #(
	parameter int unsigned MISMATCH_LIMIT = MISMATCH_LIMIT_DEF,
	parameter int unsigned GRACE_MS       = GRACE_MS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    fire,
	input  item_t   item,
	output result_t res
);

	localparam logic [7:0]  MM_LIMIT = 8'(MISMATCH_LIMIT);
	localparam logic [31:0] GRACE    = 32'(GRACE_MS);

	mode_t       mode_q, nx_mode;
	logic        latch_q, nx_latch;
	logic        fault_q, nx_fault;
	cause_t      cause_q, nx_cause;
	logic [15:0] ccnt_q, nx_ccnt;
	logic [15:0] tcnt_q, nx_tcnt;
	logic [7:0]  mm_q, nx_mm;
	logic        seen_q, nx_seen;
	logic        alive_q, nx_alive;
	logic        coh_q, nx_coh;
	logic [31:0] lchg_q, nx_lchg;
	logic [31:0] lsmp_q, nx_lsmp;

	logic        acc, go, acc_go, clr_ok, ok;
	mode_t       go_tgt;
	cause_t      go_cause;
	mode_t       req_mode;
	logic [16:0] avel, atau;
	logic        quiet_c, quiet_t;

	assign avel     = mag16(item.velocity);
	assign atau     = mag16(item.torque);
	assign req_mode = (kind_t'(item.kind) == KIND_CMP) ? MODE_CMP : MODE_TRQ;
	assign quiet_c  = (atau < {2'b0, cfg.tau_cmp_exit})
		&& (avel < {2'b0, cfg.vel_cmp_exit});
	assign quiet_t  = (atau < {2'b0, cfg.tau_torque_exit})
		&& (avel < {2'b0, cfg.vel_torque_exit});

	always_comb begin
		nx_mode  = mode_q;
		nx_latch = latch_q;
		nx_fault = fault_q;
		nx_cause = cause_q;
		nx_ccnt  = ccnt_q;
		nx_tcnt  = tcnt_q;
		nx_mm    = mm_q;
		nx_seen  = seen_q;
		nx_alive = alive_q;
		nx_coh   = coh_q;
		nx_lchg  = lchg_q;
		nx_lsmp  = lsmp_q;
		acc      = 1'b1;
		go       = 1'b0;
		go_tgt   = MODE_MON;
		go_cause = CAUSE_NONE;
		acc_go   = 1'b0;
		clr_ok   = 1'b0;

		case (kind_t'(item.kind))
			KIND_SAMPLE: begin
				nx_lsmp  = item.now_ms;
				nx_seen  = 1'b1;
				nx_alive = 1'b1;
				if (item.mode_id != {6'b0, drive_mode_id(mode_q)}) begin
					if (mm_q != 8'hFF)
						nx_mm = mm_q + 8'd1;
					nx_coh = 1'b0;
					if (nx_mm >= MM_LIMIT) begin
						nx_mm    = 8'd0;
						go       = 1'b1;
						go_tgt   = MODE_STP;
						go_cause = CAUSE_MISMATCH;
					end
				end else begin
					nx_mm  = 8'd0;
					nx_coh = 1'b1;
				end
				if (!go && cfg.auto_downgrade_enable) begin
					if (!(mode_q inside {MODE_CMP, MODE_TRQ})) begin
						nx_ccnt = 16'd0;
						nx_tcnt = 16'd0;
					end else if (!latch_q) begin
						if (mode_q == MODE_TRQ) begin
							nx_tcnt = leak(tcnt_q, quiet_t, cfg.downgrade_target,
								cfg.penalty_weight);
							if (nx_tcnt >= cfg.downgrade_target) begin
								nx_tcnt = 16'd0;
								nx_ccnt = 16'd0;
								go      = 1'b1;
								if (quiet_c) begin
									nx_fault = 1'b0;
									go_tgt   = MODE_MON;
								end else begin
									go_tgt = MODE_CMP;
								end
							end
						end else begin
							nx_ccnt = leak(ccnt_q, quiet_c, cfg.downgrade_target,
								cfg.penalty_weight);
							if (nx_ccnt >= cfg.downgrade_target) begin
								nx_ccnt  = 16'd0;
								nx_fault = 1'b0;
								go       = 1'b1;
								go_tgt   = MODE_MON;
							end
						end
					end
				end
			end
			KIND_TICK: begin
				if (!seen_q) begin
					if ((item.now_ms - lchg_q) >= GRACE) begin
						nx_seen  = 1'b1;
						nx_alive = 1'b0;
						go       = 1'b1;
						go_tgt   = MODE_STP;
						go_cause = CAUSE_UNSEEN;
					end
				end else if ((item.now_ms - lsmp_q) > {16'b0, cfg.liveness_timeout_ms}) begin
					nx_alive = 1'b0;
					if (mode_q != MODE_STP) begin
						go       = 1'b1;
						go_tgt   = MODE_STP;
						go_cause = CAUSE_TIMEOUT;
					end
				end
			end
			KIND_STOP: begin
				if (item.set_flag) begin
					go       = 1'b1;
					go_tgt   = MODE_STP;
					go_cause = CAUSE_REQUEST;
					acc_go   = 1'b1;
				end else begin
					acc = 1'b0;
				end
			end
			KIND_CMP, KIND_TRQ: begin
				if (item.set_flag) begin
					nx_fault = 1'b1;
					go       = 1'b1;
					go_tgt   = req_mode;
					acc_go   = 1'b1;
				end else if (mode_q == req_mode) begin
					go     = 1'b1;
					go_tgt = MODE_MON;
					acc_go = 1'b1;
					clr_ok = 1'b1;
				end
			end
			KIND_RESET: begin
				if (latch_q || fault_q) begin
					nx_latch = 1'b0;
					nx_fault = 1'b0;
					nx_cause = CAUSE_NONE;
					nx_ccnt  = 16'd0;
					nx_tcnt  = 16'd0;
					go       = 1'b1;
					go_tgt   = MODE_MON;
					acc_go   = 1'b1;
				end
			end
			default: acc = 1'b0;
		endcase

		ok = allowed(go_tgt, mode_q, nx_latch);
		if (go && ok) begin
			if (go_tgt == MODE_STP) begin
				nx_latch = 1'b1;
				nx_fault = 1'b1;
				nx_cause = go_cause;
			end
			nx_ccnt = 16'd0;
			nx_tcnt = 16'd0;
			nx_mode = go_tgt;
			nx_lchg = item.now_ms;
			nx_mm   = 8'd0;
		end
		if (acc_go)
			acc = ok;
		if (clr_ok && ok)
			nx_fault = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_MON;
			latch_q <= 1'b0;
			fault_q <= 1'b0;
			cause_q <= CAUSE_NONE;
			ccnt_q  <= 16'd0;
			tcnt_q  <= 16'd0;
			mm_q    <= 8'd0;
			seen_q  <= 1'b0;
			alive_q <= 1'b0;
			coh_q   <= 1'b1;
			lchg_q  <= 32'd0;
			lsmp_q  <= 32'd0;
		end else if (fire) begin
			mode_q  <= nx_mode;
			latch_q <= nx_latch;
			fault_q <= nx_fault;
			cause_q <= nx_cause;
			ccnt_q  <= nx_ccnt;
			tcnt_q  <= nx_tcnt;
			mm_q    <= nx_mm;
			seen_q  <= nx_seen;
			alive_q <= nx_alive;
			coh_q   <= nx_coh;
			lchg_q  <= nx_lchg;
			lsmp_q  <= nx_lsmp;
		end
	end

	assign res.mode_code          = nx_mode;
	assign res.accepted           = acc;
	assign res.stop_latched       = nx_latch;
	assign res.fault_flag         = nx_fault;
	assign res.fault_cause        = nx_cause;
	assign res.drive_alive        = nx_alive;
	assign res.drive_coherent     = nx_coh;
	assign res.compliant_progress = nx_ccnt;
	assign res.torque_progress    = nx_tcnt;

	`SMS_ASSERT_NOW(a_latch_in_stop, latch_q, mode_q == MODE_STP, "latch set outside safe stop")
	`SMS_ASSERT_NOW(a_latch_fault, latch_q, fault_q, "latch set without fault")
	`SMS_ASSERT_NOW(a_cause_latch, 1'b1, (cause_q != CAUSE_NONE) == latch_q, "cause out of step")
	`SMS_ASSERT_NOW(a_mm_below, 1'b1, mm_q < MM_LIMIT, "mismatch count reached limit")
	`SMS_ASSERT_NEXT(a_hold_idle, !fire, $stable(mode_q) && $stable(latch_q), "state moved")

endmodule

FILE: sv/safety_mode_supervisor.sv
// Safety mode supervisor: top level with event input register and result register.
// Depends on smsup_pkg, smsup_cfg and smsup_core.
`timescale 1ns / 1ps

// Takes one event word per clock while item_stall is low and returns one result
// word per event, in order. A word is held in the input register, where the mode,
// fault and counter update is evaluated, and then lands in the result register,
// which raises result_valid; the supervisor state is updated in the same edge
// that loads the result, so a new word may follow in every cycle while item_stall
// is low. item_stall rises only while both registers are full and result_stall is
// high. Configuration must be written through the APB-style port at byte address
// 4*index while no event is in flight; the block itself does not enforce this.

module safety_mode_supervisor import smsup_pkg::*; #(
	parameter int unsigned MISMATCH_LIMIT = MISMATCH_LIMIT_DEF,
	parameter int unsigned GRACE_MS       = GRACE_MS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [2:0]         kind,
	input  logic               set_flag,
	input  logic [7:0]         mode_id,
	input  logic signed [15:0] velocity,
	input  logic signed [15:0] torque,
	input  logic [31:0]        now_ms,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [1:0]         mode_code,
	output logic               accepted,
	output logic               stop_latched,
	output logic               fault_flag,
	output logic [2:0]         fault_cause,
	output logic               drive_alive,
	output logic               drive_coherent,
	output logic [15:0]        compliant_progress,
	output logic [15:0]        torque_progress
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_c, res_q;
	logic    res_valid_q;
	logic    fire, take;

	smsup_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	smsup_core #(
		.MISMATCH_LIMIT (MISMATCH_LIMIT),
		.GRACE_MS       (GRACE_MS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (fire),
		.item   (item_s1),
		.res    (res_c)
	);

	assign fire       = valid_s1 && !(res_valid_q && result_stall);
	assign item_stall = valid_s1 && res_valid_q && result_stall;
	assign take       = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			valid_s1    <= take || (valid_s1 && !fire);
			res_valid_q <= fire || (res_valid_q && result_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.kind     <= kind;
			item_s1.set_flag <= set_flag;
			item_s1.mode_id  <= mode_id;
			item_s1.velocity <= velocity;
			item_s1.torque   <= torque;
			item_s1.now_ms   <= now_ms;
		end
		if (fire)
			res_q <= res_c;
	end

	assign result_valid       = res_valid_q;
	assign mode_code          = res_q.mode_code;
	assign accepted           = res_q.accepted;
	assign stop_latched       = res_q.stop_latched;
	assign fault_flag         = res_q.fault_flag;
	assign fault_cause        = res_q.fault_cause;
	assign drive_alive        = res_q.drive_alive;
	assign drive_coherent     = res_q.drive_coherent;
	assign compliant_progress = res_q.compliant_progress;
	assign torque_progress    = res_q.torque_progress;

endmodule

FILE: bench/safety_mode_supervisor_tb.sv
// Self-checking testbench for the safety mode supervisor: directed events, then random
// event streams over several register settings, each result word checked in order.
// Depends on smsup_pkg and safety_mode_supervisor.
`timescale 1ns / 1ps

module safety_mode_supervisor_tb;
	import smsup_pkg::*;

	localparam logic [2:0] KIND_SPARE_A = 3'd6;
	localparam logic [2:0] KIND_SPARE_B = 3'd7;
	localparam logic [7:0] DRV_ID_MON = 8'd0;
	localparam logic [7:0] DRV_ID_TRQ = 8'd1;
	localparam logic [7:0] DRV_ID_CMP = 8'd2;
	localparam logic [7:0] DRV_ID_STP = 8'd3;
	localparam int unsigned CYCLE_LIMIT = 400000;

	class supervisor_scoreboard;
		bit        dg_enable;
		bit [14:0] tau_cmp, tau_trq, vel_cmp, vel_trq;
		bit [15:0] dg_target;
		bit [7:0]  penalty;
		bit [15:0] timeout_ms;
		mode_t     mode;
		bit        latched, faulted;
		cause_t    cause;
		bit [15:0] cmp_cnt, trq_cnt;
		bit [7:0]  miss_cnt;
		bit        seen, alive, coherent;
		bit [31:0] changed_at, sampled_at;
		result_t   status_due[$];
		int        errors;

		function new();
			dg_enable = 1'b0;
			tau_cmp = TAU_CMP_RST;
			tau_trq = TAU_TRQ_RST;
			vel_cmp = VEL_CMP_RST;
			vel_trq = VEL_TRQ_RST;
			dg_target = DG_TARGET_RST;
			penalty = PENALTY_RST;
			timeout_ms = TIMEOUT_RST;
			mode = MODE_MON;
			latched = 1'b0;
			faulted = 1'b0;
			cause = CAUSE_NONE;
			cmp_cnt = '0;
			trq_cnt = '0;
			miss_cnt = '0;
			seen = 1'b0;
			alive = 1'b0;
			coherent = 1'b1;
			changed_at = '0;
			sampled_at = '0;
			errors = 0;
		endfunction

		function void set_reg(reg_idx_t idx, bit [31:0] v);
			case (idx)
				REG_AUTO_DG:   dg_enable = v[0];
				REG_TAU_CMP:   tau_cmp = v[14:0];
				REG_TAU_TRQ:   tau_trq = v[14:0];
				REG_VEL_CMP:   vel_cmp = v[14:0];
				REG_VEL_TRQ:   vel_trq = v[14:0];
				REG_DG_TARGET: dg_target = v[15:0];
				REG_PENALTY:   penalty = v[7:0];
				REG_TIMEOUT:   timeout_ms = v[15:0];
				default: ;
			endcase
		endfunction

		function bit [16:0] magnitude(bit [15:0] raw);
			return raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
		endfunction

		function bit [7:0] drive_id(mode_t m);
			case (m)
				MODE_CMP: return DRV_ID_CMP;
				MODE_TRQ: return DRV_ID_TRQ;
				MODE_STP: return DRV_ID_STP;
				default:  return DRV_ID_MON;
			endcase
		endfunction

		function bit [15:0] leaky(bit [15:0] c, bit quiet);
			bit [16:0] up;
			up = {1'b0, c} + 17'd1;
			if (quiet)
				return (up < {1'b0, dg_target}) ? up[15:0] : dg_target;
			return (c > {8'h00, penalty}) ? (c - {8'h00, penalty}) : 16'd0;
		endfunction

		function bit move_to(mode_t tgt, cause_t why, bit [31:0] now);
			if (latched && tgt != MODE_STP)
				return 1'b0;
			if (tgt != mode && mode == MODE_STP && tgt != MODE_MON)
				return 1'b0;
			if (tgt == MODE_STP) begin
				latched = 1'b1;
				faulted = 1'b1;
				cause = why;
			end
			cmp_cnt = '0;
			trq_cnt = '0;
			mode = tgt;
			changed_at = now;
			miss_cnt = '0;
			return 1'b1;
		endfunction

		function bit [16:0] vel_cmp_ext(bit [14:0] bound);
			return {2'b00, bound};
		endfunction

		function void on_sample(item_t w);
			bit [16:0] av, at;
			bit quiet_c, quiet_t;
			av = magnitude(w.velocity);
			at = magnitude(w.torque);
			sampled_at = w.now_ms;
			seen = 1'b1;
			alive = 1'b1;
			if (w.mode_id != drive_id(mode)) begin
				if (miss_cnt != 8'hFF)
					miss_cnt++;
				coherent = 1'b0;
				if (miss_cnt >= MISMATCH_LIMIT_DEF) begin
					miss_cnt = '0;
					void'(move_to(MODE_STP, CAUSE_MISMATCH, w.now_ms));
					return;
				end
			end else begin
				miss_cnt = '0;
				coherent = 1'b1;
			end
			if (!dg_enable)
				return;
			if (!(mode inside {MODE_CMP, MODE_TRQ})) begin
				cmp_cnt = '0;
				trq_cnt = '0;
				return;
			end
			if (latched)
				return;
			quiet_c = at < vel_cmp_ext(tau_cmp) && av < vel_cmp_ext(vel_cmp);
			if (mode == MODE_TRQ) begin
				quiet_t = at < vel_cmp_ext(tau_trq) && av < vel_cmp_ext(vel_trq);
				trq_cnt = leaky(trq_cnt, quiet_t);
				if (trq_cnt >= dg_target) begin
					trq_cnt = '0;
					cmp_cnt = '0;
					if (quiet_c) begin
						faulted = 1'b0;
						void'(move_to(MODE_MON, CAUSE_NONE, w.now_ms));
					end else begin
						void'(move_to(MODE_CMP, CAUSE_NONE, w.now_ms));
					end
				end
			end else begin
				cmp_cnt = leaky(cmp_cnt, quiet_c);
				if (cmp_cnt >= dg_target) begin
					cmp_cnt = '0;
					faulted = 1'b0;
					void'(move_to(MODE_MON, CAUSE_NONE, w.now_ms));
				end
			end
		endfunction

		function void on_tick(bit [31:0] now);
			bit [31:0] up_ms, age;
			up_ms = now - changed_at;
			age = now - sampled_at;
			if (!seen) begin
				if (up_ms < GRACE_MS_DEF)
					return;
				seen = 1'b1;
				alive = 1'b0;
				void'(move_to(MODE_STP, CAUSE_UNSEEN, now));
				return;
			end
			if (age > {16'h0000, timeout_ms}) begin
				alive = 1'b0;
				if (mode != MODE_STP)
					void'(move_to(MODE_STP, CAUSE_TIMEOUT, now));
			end
		endfunction

		function bit on_request(mode_t m, bit set, bit [31:0] now);
			if (set) begin
				faulted = 1'b1;
				return move_to(m, CAUSE_NONE, now);
			end
			if (mode != m)
				return 1'b1;
			if (move_to(MODE_MON, CAUSE_NONE, now)) begin
				faulted = 1'b0;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_event(item_t w);
			bit acc;
			result_t r;
			acc = 1'b1;
			case (w.kind)
				KIND_SAMPLE: on_sample(w);
				KIND_TICK:   on_tick(w.now_ms);
				KIND_STOP:
					acc = w.set_flag ? move_to(MODE_STP, CAUSE_REQUEST, w.now_ms) : 1'b0;
				KIND_CMP:    acc = on_request(MODE_CMP, w.set_flag, w.now_ms);
				KIND_TRQ:    acc = on_request(MODE_TRQ, w.set_flag, w.now_ms);
				KIND_RESET: begin
					if (latched || faulted) begin
						latched = 1'b0;
						faulted = 1'b0;
						cause = CAUSE_NONE;
						cmp_cnt = '0;
						trq_cnt = '0;
						acc = move_to(MODE_MON, CAUSE_NONE, w.now_ms);
					end
				end
				default: acc = 1'b0;
			endcase
			r.mode_code = mode;
			r.accepted = acc;
			r.stop_latched = latched;
			r.fault_flag = faulted;
			r.fault_cause = cause;
			r.drive_alive = alive;
			r.drive_coherent = coherent;
			r.compliant_progress = cmp_cnt;
			r.torque_progress = trq_cnt;
			status_due.push_back(r);
		endfunction

		function void check_status(result_t got);
			result_t want;
			if (status_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word: %h", got);
				return;
			end
			want = status_due.pop_front();
			if (got.mode_code !== want.mode_code || got.accepted !== want.accepted ||
					got.stop_latched !== want.stop_latched ||
					got.fault_flag !== want.fault_flag ||
					got.fault_cause !== want.fault_cause ||
					got.drive_alive !== want.drive_alive ||
					got.drive_coherent !== want.drive_coherent ||
					got.compliant_progress !== want.compliant_progress ||
					got.torque_progress !== want.torque_progress) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch exp: mode %0d acc %0d latch %0d fault %0d cause %0d",
						want.mode_code, want.accepted, want.stop_latched, want.fault_flag,
						want.fault_cause);
					$display("              alive %0d coh %0d cmp %0d trq %0d",
						want.drive_alive, want.drive_coherent,
						want.compliant_progress, want.torque_progress);
					$display("         got: mode %0d acc %0d latch %0d fault %0d cause %0d",
						got.mode_code, got.accepted, got.stop_latched, got.fault_flag,
						got.fault_cause);
					$display("              alive %0d coh %0d cmp %0d trq %0d",
						got.drive_alive, got.drive_coherent,
						got.compliant_progress, got.torque_progress);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid = 1'b0;
	logic        item_stall;
	item_t       word_out = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [1:0]  mode_code;
	logic        accepted;
	logic        stop_latched;
	logic        fault_flag;
	logic [2:0]  fault_cause;
	logic        drive_alive;
	logic        drive_coherent;
	logic [15:0] compliant_progress;
	logic [15:0] torque_progress;

	supervisor_scoreboard sb;
	int unsigned send_idle_pct = 7;
	int unsigned recv_idle_pct = 52;
	int unsigned cycle_count = 0;
	bit [31:0]   t_ms = '0;

	safety_mode_supervisor DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.kind(word_out.kind),
		.set_flag(word_out.set_flag),
		.mode_id(word_out.mode_id),
		.velocity(word_out.velocity),
		.torque(word_out.torque),
		.now_ms(word_out.now_ms),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.mode_code(mode_code),
		.accepted(accepted),
		.stop_latched(stop_latched),
		.fault_flag(fault_flag),
		.fault_cause(fault_cause),
		.drive_alive(drive_alive),
		.drive_coherent(drive_coherent),
		.compliant_progress(compliant_progress),
		.torque_progress(torque_progress)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("safety_mode_supervisor verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_status({mode_code, accepted, stop_latched, fault_flag, fault_cause,
				drive_alive, drive_coherent, compliant_progress, torque_progress});
	end

	task automatic send_word(item_t w);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		word_out <= w;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sb.note_event(w);
	endtask

	task automatic send_event(logic [2:0] k, bit s, logic [7:0] id, logic [15:0] v,
			logic [15:0] q, logic [31:0] now);
		item_t w;
		w.kind = k;
		w.set_flag = s;
		w.mode_id = id;
		w.velocity = v;
		w.torque = q;
		w.now_ms = now;
		send_word(w);
	endtask

	// hold off until every result word is back
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.status_due.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	function automatic logic [15:0] quiet_value(bit [14:0] bound);
		logic [15:0] m;
		if (bound == 0)
			return 16'd0;
		m = 16'($urandom_range(bound - 1, 0));
		return $urandom_range(1) ? -m : m;
	endfunction

	function automatic item_t make_word();
		item_t w;
		int unsigned pick, sample_share;
		bit [14:0] vb, qb;
		w.kind = 3'($urandom_range(7));
		w.set_flag = 1'($urandom_range(1));
		w.mode_id = 8'($urandom_range(255));
		w.velocity = 16'($urandom);
		w.torque = 16'($urandom);
		w.now_ms = $urandom;
		pick = $urandom_range(99);
		if (pick >= 95)
			return w;
		sample_share = (sb.dg_enable && (sb.mode inside {MODE_CMP, MODE_TRQ})) ? 65 : 40;
		t_ms += $urandom_range(30);
		if (pick < sample_share) begin
			w.kind = KIND_SAMPLE;
			if ($urandom_range(19) != 0)
				w.mode_id = sb.drive_id(sb.mode);
			if ($urandom_range(3) != 0) begin
				if (sb.mode == MODE_TRQ && $urandom_range(1)) begin
					vb = sb.vel_trq;
					qb = sb.tau_trq;
				end else begin
					vb = sb.vel_cmp;
					qb = sb.tau_cmp;
				end
				w.velocity = quiet_value(vb);
				w.torque = quiet_value(qb);
			end
		end else if (pick < sample_share + 15) begin
			w.kind = KIND_TICK;
			case ($urandom_range(9))
				0: t_ms = sb.sampled_at + sb.timeout_ms;
				1: t_ms = sb.sampled_at + sb.timeout_ms + 1;
				2: t_ms += sb.timeout_ms + $urandom_range(40);
				default: ;
			endcase
		end else if (pick < 90) begin
			case ($urandom_range(2))
				0: w.kind = KIND_STOP;
				1: w.kind = KIND_CMP;
				default: w.kind = KIND_TRQ;
			endcase
			w.set_flag = $urandom_range(9) < 7;
		end else begin
			w.kind = KIND_RESET;
		end
		w.now_ms = t_ms;
		return w;
	endfunction

	task automatic run_random(int n);
		for (int i = 0; i < n; i++)
			send_word(make_word());
	endtask

	task automatic run_directed();
		send_event(KIND_TICK, 1'b0, DRV_ID_MON, 16'h0000, 16'h0000, 32'd0);
		send_event(KIND_TICK, 1'b0, DRV_ID_MON, 16'h0000, 16'h0000, GRACE_MS_DEF - 1);
		send_event(KIND_TICK, 1'b0, DRV_ID_MON, 16'h0000, 16'h0000, GRACE_MS_DEF);
		send_event(KIND_STOP, 1'b0, DRV_ID_MON, 16'h0000, 16'h0000, 32'd3010);
		send_event(KIND_CMP, 1'b1, DRV_ID_MON, 16'h0000, 16'h0000, 32'd3020);
		send_event(KIND_TRQ, 1'b0, DRV_ID_MON, 16'h0000, 16'h0000, 32'd3030);
		send_event(KIND_RESET, 1'b0, DRV_ID_MON, 16'h0000, 16'h0000, 32'd3100);
		send_event(KIND_RESET, 1'b1, DRV_ID_MON, 16'h0000, 16'h0000, 32'd3101);
		send_event(KIND_SAMPLE, 1'b0, DRV_ID_MON, 16'h7FFF, 16'h8000, 32'd3110);
		send_event(KIND_SAMPLE, 1'b1, 8'hFF, 16'h8000, 16'h7FFF, 32'd3120);
		send_event(KIND_TRQ, 1'b1, DRV_ID_MON, 16'h0000, 16'h0000, 32'd3130);
		send_event(KIND_SAMPLE, 1'b0, DRV_ID_TRQ, 16'h0000, 16'hFFFF, 32'd3140);
		send_event(KIND_CMP, 1'b1, DRV_ID_MON, 16'h0000, 16'h0000, 32'd3150);
		send_event(KIND_SAMPLE, 1'b0, DRV_ID_CMP, 16'hFFFF, 16'h0001, 32'd3160);
		send_event(KIND_CMP, 1'b0, DRV_ID_MON, 16'h0000, 16'h0000, 32'd3170);
		send_event(KIND_SPARE_A, 1'b1, DRV_ID_MON, 16'h0000, 16'h0000, 32'd3180);
		send_event(KIND_SPARE_B, 1'b0, DRV_ID_MON, 16'h0000, 16'h0000, 32'd3190);
		repeat (5)
			send_event(KIND_SAMPLE, 1'b0, DRV_ID_STP, 16'h0100, 16'hFF00, 32'd3200);
		send_event(KIND_STOP, 1'b1, DRV_ID_MON, 16'h0000, 16'h0000, 32'd3210);
		send_event(KIND_RESET, 1'b0, DRV_ID_MON, 16'h0000, 16'h0000, 32'hFFFF_FFF0);
		send_event(KIND_SAMPLE, 1'b0, DRV_ID_MON, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
		send_event(KIND_TICK, 1'b0, DRV_ID_MON, 16'h0000, 16'h0000, 32'd499);
		send_event(KIND_TICK, 1'b0, DRV_ID_MON, 16'h0000, 16'h0000, 32'd500);
		send_event(KIND_RESET, 1'b0, DRV_ID_MON, 16'h0000, 16'h0000, 32'd501);
		send_event(KIND_STOP, 1'b1, DRV_ID_MON, 16'h0000, 16'h0000, 32'd502);
		send_event(KIND_RESET, 1'b0, DRV_ID_MON, 16'h0000, 16'h0000, 32'd503);
	endtask

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		t_ms = 32'd600;
		run_random(280);

		drain();
		write_reg(REG_AUTO_DG, 32'd1);
		write_reg(REG_TAU_CMP, 32'd32767);
		write_reg(REG_TAU_TRQ, 32'd32767);
		write_reg(REG_VEL_CMP, 32'd32767);
		write_reg(REG_VEL_TRQ, 32'd32767);
		write_reg(REG_DG_TARGET, 32'd4);
		write_reg(REG_PENALTY, 32'd1);
		write_reg(REG_TIMEOUT, 32'd65535);
		run_random(300);

		send_idle_pct = 52;
		recv_idle_pct = 7;
		drain();
		write_reg(REG_TAU_CMP, 32'd0);
		write_reg(REG_TAU_TRQ, 32'd0);
		write_reg(REG_VEL_CMP, 32'd0);
		write_reg(REG_VEL_TRQ, 32'd0);
		write_reg(REG_DG_TARGET, 32'd0);
		write_reg(REG_PENALTY, 32'd255);
		write_reg(REG_TIMEOUT, 32'd1);
		t_ms = 32'hFFFF_FC00;
		run_random(200);

		drain();
		write_reg(REG_TAU_CMP, $urandom_range(32767));
		write_reg(REG_TAU_TRQ, $urandom_range(32767));
		write_reg(REG_VEL_CMP, $urandom_range(32767));
		write_reg(REG_VEL_TRQ, $urandom_range(32767));
		write_reg(REG_DG_TARGET, 32'd65535);
		write_reg(REG_PENALTY, 32'd0);
		write_reg(REG_TIMEOUT, $urandom_range(65535, 1));
		run_random(200);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		drain();
		write_reg(REG_TAU_CMP, $urandom_range(32767));
		write_reg(REG_TAU_TRQ, $urandom_range(32767));
		write_reg(REG_VEL_CMP, $urandom_range(32767));
		write_reg(REG_VEL_TRQ, $urandom_range(32767));
		write_reg(REG_DG_TARGET, $urandom_range(40, 1));
		write_reg(REG_PENALTY, $urandom_range(255));
		write_reg(REG_TIMEOUT, $urandom_range(2000, 1));
		run_random(320);

		drain();
		write_reg(REG_AUTO_DG, 32'd0);
		write_reg(REG_DG_TARGET, 32'd1);
		write_reg(REG_TIMEOUT, 32'd500);
		run_random(300);

		drain();
		sb.errors += sb.status_due.size();
		if (sb.errors == 0)
			$display("safety_mode_supervisor verification clean");
		else
			$display("safety_mode_supervisor verification failed");
		$finish;
	end

endmodule

FILE: files.f
+incdir+sv
sv/smsup_pkg.sv
sv/smsup_cfg.sv
sv/smsup_core.sv
sv/safety_mode_supervisor.sv
bench/safety_mode_supervisor_tb.sv
